// ===== hdl/ohlc_pkg.sv =====
`timescale 1ns / 1ps
package ohlc_pkg;
  localparam int unsigned SymbolSlots = 16;
  localparam logic [31:0] DefaultInterval = 32'd300;

  localparam logic [3:0] REQ_BID      = 4'd0;
  localparam logic [3:0] REQ_ASK      = 4'd1;
  localparam logic [3:0] REQ_TRADE    = 4'd2;
  localparam logic [3:0] REQ_PAIR     = 4'd3;
  localparam logic [3:0] REQ_SNAP     = 4'd4;
  localparam logic [3:0] REQ_CDL_BID  = 4'd5;
  localparam logic [3:0] REQ_CDL_ASK  = 4'd6;
  localparam logic [3:0] REQ_CDL_TRD  = 4'd7;
  localparam logic [3:0] REQ_FLUSH    = 4'd8;

  localparam logic [1:0] CFG_INTERVAL = 2'd0;
  localparam logic [1:0] CFG_OFFSET   = 2'd1;
  localparam logic [1:0] CFG_DRY      = 2'd2;

  localparam logic [1:0] SIDE_BID   = 2'd0;
  localparam logic [1:0] SIDE_ASK   = 2'd1;
  localparam logic [1:0] SIDE_TRADE = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic load;       // capture the request
    logic div_start;  // start remainder
    logic merge;      // merge request into store
    logic roll_end;   // set new bucket end
    logic clear_end;  // bucket end to zero
    logic clear_all;  // clear valid bits
    logic scan_start; // reset scan pointer
    logic scan_step;  // advance scan
    logic out_load;   // load output register from scan position
  } ohlc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_flush;
    logic is_unknown;
    logic need_roll;
    logic div_done;
    logic scan_hit;   // current scan position has a candle
    logic scan_last;  // no further candle after the current one
    logic scan_end;   // scan past last position
  } ohlc_sts_t;
endpackage

// ===== hdl/ohlc_datapath.sv =====
`timescale 1ns / 1ps
module ohlc_datapath #(
  parameter int unsigned SLOTS = ohlc_pkg::SymbolSlots
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ohlc_pkg::ohlc_cmd_t cmd,
  output ohlc_pkg::ohlc_sts_t sts,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [3:0]        in_req_type,
  input  logic [3:0]        in_symbol,
  input  logic [31:0]       in_seconds,
  input  logic [31:0]       in_value_a,
  input  logic [31:0]       in_value_b,
  input  logic [31:0]       in_cdl_open,
  input  logic [31:0]       in_cdl_high,
  input  logic [31:0]       in_cdl_low,
  output logic [3:0]        out_symbol,
  output logic [1:0]        out_side,
  output logic [31:0]       out_end_stamp,
  output logic [31:0]       out_start_stamp,
  output logic [31:0]       out_open_price,
  output logic [31:0]       out_high_price,
  output logic [31:0]       out_low_price,
  output logic [31:0]       out_close_price,
  output logic [31:0]       out_event_count,
  output logic              out_last_of_run
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  // scan position = slot*3 + side
  localparam int unsigned POS = SLOTS * 3;
  localparam int unsigned PW = $clog2(POS + 1);

  typedef struct packed {
    logic [31:0] o, h, l, c, n;
  } bar_t;

  logic [31:0] interval_r, offset_r;
  logic        dry_r;
  logic [31:0] end_r;

  logic [3:0]  typ_r;
  logic [3:0]  sym_r;
  logic [31:0] sec_r, va_r, vb_r, co_r, ch_r, cl_r;

  bar_t bars_r [SLOTS][3];
  logic [2:0] vld_r [SLOTS];

  // remainder unit: restoring, one bit a cycle
  logic [31:0] dvd_r, rem_r;
  logic [5:0]  dcnt_r;
  logic        dbusy_r;
  logic [32:0] rtrial;

  always_comb begin
    rtrial = {rem_r, dvd_r[31]} - {1'b0, interval_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dbusy_r <= 1'b0;
      dcnt_r  <= '0;
    end else if (cmd.div_start) begin
      dvd_r   <= sec_r - offset_r;
      rem_r   <= '0;
      dcnt_r  <= 6'd32;
      dbusy_r <= (interval_r != '0);
    end else if (dbusy_r) begin
      dvd_r <= {dvd_r[30:0], 1'b0};
      if (!rtrial[32]) rem_r <= rtrial[31:0];
      else rem_r <= {rem_r[30:0], dvd_r[31]};
      dcnt_r <= dcnt_r - 6'd1;
      if (dcnt_r == 6'd1) dbusy_r <= 1'b0;
    end
  end

  logic [31:0] al;
  logic        span;
  assign al   = sec_r - rem_r;
  assign span = (typ_r >= ohlc_pkg::REQ_SNAP);

  // merge logic
  function automatic bar_t put_price(bar_t b, logic v_ok, logic [31:0] v);
    bar_t r;
    r = b;
    r.c = v;
    if (!v_ok) begin
      r.o = v; r.h = v; r.l = v; r.n = 32'd1;
    end else begin
      if (v > b.h) r.h = v;
      else if (v < b.l) r.l = v;
      r.n = b.n + 32'd1;
    end
    return r;
  endfunction

  function automatic bar_t put_cdl(bar_t b, logic v_ok, logic [31:0] o, logic [31:0] h,
                                   logic [31:0] l, logic [31:0] c);
    bar_t r;
    r = b;
    r.c = c;
    if (!v_ok) begin
      r.o = o; r.h = h; r.l = l; r.n = 32'd1;
    end else begin
      if (h > b.h) r.h = h;
      if (l < b.l) r.l = l;
      r.n = b.n + 32'd1;
    end
    return r;
  endfunction

  logic [SW-1:0] sidx;
  logic          sym_ok;
  assign sidx   = sym_r[SW-1:0];
  assign sym_ok = ({28'd0, sym_r} < 32'(SLOTS));

  // scan
  logic [PW-1:0] pos_r;
  logic [POS-1:0] hit_vec;
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      hit_vec[s*3]     = vld_r[s][0] | vld_r[s][1];
      hit_vec[s*3 + 1] = vld_r[s][0] | vld_r[s][1];
      hit_vec[s*3 + 2] = vld_r[s][2];
    end
  end
  logic [POS-1:0] above;
  always_comb begin
    for (int p = 0; p < POS; p++) above[p] = (PW'(p) > pos_r) & hit_vec[p];
  end

  // slot and side of the scan position, stepped alongside it
  logic [SW-1:0] pslot_r;
  logic [1:0]    pside_r;

  assign sts.is_flush   = (typ_r == ohlc_pkg::REQ_FLUSH);
  assign sts.is_unknown = (typ_r > ohlc_pkg::REQ_FLUSH);
  assign sts.need_roll  = (end_r == '0) || (span ? (sec_r > end_r) : (sec_r >= end_r));
  assign sts.div_done   = !dbusy_r;
  assign sts.scan_end   = (pos_r >= PW'(POS));
  assign sts.scan_hit   = !sts.scan_end && hit_vec[pos_r] && !dry_r;
  assign sts.scan_last  = (above == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      interval_r <= ohlc_pkg::DefaultInterval;
      offset_r   <= '0;
      dry_r      <= 1'b0;
      end_r      <= '0;
      pos_r      <= '0;
      pslot_r    <= '0;
      pside_r    <= ohlc_pkg::SIDE_BID;
      for (int s = 0; s < SLOTS; s++) vld_r[s] <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          ohlc_pkg::CFG_INTERVAL: interval_r <= cfg_data;
          ohlc_pkg::CFG_OFFSET:   offset_r   <= cfg_data;
          ohlc_pkg::CFG_DRY:      dry_r      <= cfg_data[0];
          default: ;
        endcase
      end
      if (cmd.clear_end) end_r <= '0;
      if (cmd.roll_end) end_r <= (span && sec_r == al) ? sec_r : al + interval_r;
      if (cmd.scan_start) begin
        pos_r   <= '0;
        pslot_r <= '0;
        pside_r <= ohlc_pkg::SIDE_BID;
      end else if (cmd.scan_step) begin
        pos_r <= pos_r + PW'(1);
        if (pside_r == ohlc_pkg::SIDE_TRADE) begin
          pside_r <= ohlc_pkg::SIDE_BID;
          pslot_r <= pslot_r + SW'(1);
        end else begin
          pside_r <= pside_r + 2'd1;
        end
      end
      if (cmd.clear_all) for (int s = 0; s < SLOTS; s++) vld_r[s] <= '0;
      if (cmd.merge && sym_ok) begin
        case (typ_r)
          ohlc_pkg::REQ_BID, ohlc_pkg::REQ_CDL_BID: vld_r[sidx][0] <= 1'b1;
          ohlc_pkg::REQ_ASK, ohlc_pkg::REQ_CDL_ASK: vld_r[sidx][1] <= 1'b1;
          ohlc_pkg::REQ_TRADE, ohlc_pkg::REQ_CDL_TRD: vld_r[sidx][2] <= 1'b1;
          ohlc_pkg::REQ_PAIR, ohlc_pkg::REQ_SNAP: begin
            vld_r[sidx][0] <= 1'b1;
            vld_r[sidx][1] <= 1'b1;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      typ_r <= in_req_type;
      sym_r <= in_symbol;
      sec_r <= in_seconds;
      va_r  <= in_value_a;
      vb_r  <= in_value_b;
      co_r  <= in_cdl_open;
      ch_r  <= in_cdl_high;
      cl_r  <= in_cdl_low;
    end
    if (cmd.merge && sym_ok) begin
      case (typ_r)
        ohlc_pkg::REQ_BID:
          bars_r[sidx][0] <= put_price(bars_r[sidx][0], vld_r[sidx][0], va_r);
        ohlc_pkg::REQ_ASK:
          bars_r[sidx][1] <= put_price(bars_r[sidx][1], vld_r[sidx][1], va_r);
        ohlc_pkg::REQ_TRADE:
          bars_r[sidx][2] <= put_price(bars_r[sidx][2], vld_r[sidx][2], va_r);
        ohlc_pkg::REQ_PAIR, ohlc_pkg::REQ_SNAP: begin
          bars_r[sidx][0] <= put_price(bars_r[sidx][0], vld_r[sidx][0], va_r);
          bars_r[sidx][1] <= put_price(bars_r[sidx][1], vld_r[sidx][1], vb_r);
        end
        ohlc_pkg::REQ_CDL_BID:
          bars_r[sidx][0] <= put_cdl(bars_r[sidx][0], vld_r[sidx][0], co_r, ch_r, cl_r, va_r);
        ohlc_pkg::REQ_CDL_ASK:
          bars_r[sidx][1] <= put_cdl(bars_r[sidx][1], vld_r[sidx][1], co_r, ch_r, cl_r, va_r);
        ohlc_pkg::REQ_CDL_TRD:
          bars_r[sidx][2] <= put_cdl(bars_r[sidx][2], vld_r[sidx][2], co_r, ch_r, cl_r, va_r);
        default: ;
      endcase
    end
    if (cmd.out_load) begin
      out_symbol      <= 4'(pslot_r);
      out_side        <= pside_r;
      out_end_stamp   <= end_r;
      out_start_stamp <= end_r - interval_r;
      // empty side of a pair reads as zero
      if (vld_r[pslot_r][pside_r]) begin
        out_open_price  <= bars_r[pslot_r][pside_r].o;
        out_high_price  <= bars_r[pslot_r][pside_r].h;
        out_low_price   <= bars_r[pslot_r][pside_r].l;
        out_close_price <= bars_r[pslot_r][pside_r].c;
        out_event_count <= bars_r[pslot_r][pside_r].n;
      end else begin
        out_open_price  <= '0;
        out_high_price  <= '0;
        out_low_price   <= '0;
        out_close_price <= '0;
        out_event_count <= '0;
      end
      out_last_of_run <= sts.scan_last;
    end
  end
endmodule

// ===== hdl/ohlc_ctrl.sv =====
`timescale 1ns / 1ps
module ohlc_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output ohlc_pkg::ohlc_cmd_t cmd,
  input  ohlc_pkg::ohlc_sts_t sts
);
  typedef enum logic [2:0] {
    S_IDLE, S_DECIDE, S_DIV, S_SCAN, S_SEND, S_FINISH
  } state_t;

  state_t state_r;
  logic   out_valid_r;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    cmd = '0;
    case (state_r)
      S_IDLE: cmd.load = in_valid;
      S_DECIDE: begin
        if (!sts.is_unknown && !sts.is_flush && !sts.need_roll) cmd.merge = 1'b1;
        if (!sts.is_unknown && (sts.is_flush || sts.need_roll)) begin
          cmd.div_start  = !sts.is_flush;
          cmd.scan_start = 1'b1;
        end
      end
      S_SCAN: begin
        if (!sts.scan_end) begin
          cmd.scan_step = 1'b1;
          cmd.out_load  = sts.scan_hit;
        end
      end
      S_SEND: ;
      S_FINISH: begin
        cmd.clear_all = 1'b1;
      end
      S_DIV: begin
        // a rollover sets the new end and merges the request into the empty store
        if (sts.div_done) begin
          cmd.roll_end  = !sts.is_flush;
          cmd.clear_end = sts.is_flush;
          cmd.merge     = !sts.is_flush;
        end
      end
      default: ;
    endcase
  end

  // flush vs roll is remembered in the captured type
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: if (in_valid) state_r <= S_DECIDE;
        S_DECIDE: begin
          if (sts.is_unknown || !(sts.is_flush || sts.need_roll)) state_r <= S_IDLE;
          else state_r <= S_SCAN;
        end
        S_SCAN: begin
          if (sts.scan_end) state_r <= S_FINISH;
          else if (sts.scan_hit) begin
            out_valid_r <= 1'b1;
            state_r     <= S_SEND;
          end
        end
        S_SEND: begin
          if (out_ready) begin
            out_valid_r <= 1'b0;
            state_r     <= S_SCAN;
          end
        end
        S_FINISH: state_r <= S_DIV;
        S_DIV: begin
          if (sts.div_done) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== hdl/ohlc_candle_aggregator.sv =====
`timescale 1ns / 1ps
// channel   | direction | handshake
// in_*      | input     | in_valid / in_ready
// out_*     | output    | out_valid / out_ready
// cfg_*     | input     | cfg_we, no wait
// a plain update captures the request, then merges it into one slot
// a rollover or flush captures and decides, then scans all slots*3 positions one a cycle,
// pausing to send each candle and for stall time on out_ready, then ends the scan,
// clears the store, then sets the bucket end and merges the request (a flush clears the end)
// the remainder unit runs under the scan; S_DIV waits for it if the scan ends first
// reset is synchronous and clears the store valid bits and bucket end at once
module ohlc_candle_aggregator #(
  parameter int unsigned SYMBOL_SLOTS = ohlc_pkg::SymbolSlots
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic [3:0]  in_symbol,
  input  logic [31:0] in_seconds,
  input  logic [31:0] in_value_a,
  input  logic [31:0] in_value_b,
  input  logic [31:0] in_cdl_open,
  input  logic [31:0] in_cdl_high,
  input  logic [31:0] in_cdl_low,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  out_symbol,
  output logic [1:0]  out_side,
  output logic [31:0] out_end_stamp,
  output logic [31:0] out_start_stamp,
  output logic [31:0] out_open_price,
  output logic [31:0] out_high_price,
  output logic [31:0] out_low_price,
  output logic [31:0] out_close_price,
  output logic [31:0] out_event_count,
  output logic        out_last_of_run
);
  ohlc_pkg::ohlc_cmd_t cmd;
  ohlc_pkg::ohlc_sts_t sts;

  ohlc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready, .cmd, .sts
  );

  ohlc_datapath #(.SLOTS(SYMBOL_SLOTS)) u_dp (
    .clk, .rst_n, .cmd, .sts, .cfg_we, .cfg_index, .cfg_data,
    .in_req_type, .in_symbol, .in_seconds, .in_value_a, .in_value_b,
    .in_cdl_open, .in_cdl_high, .in_cdl_low,
    .out_symbol, .out_side, .out_end_stamp, .out_start_stamp,
    .out_open_price, .out_high_price, .out_low_price, .out_close_price,
    .out_event_count, .out_last_of_run
  );
endmodule

// ===== bench/tb_ohlc_candle_aggregator.sv =====
`timescale 1ns / 1ps
module tb_ohlc_candle_aggregator;
  typedef struct packed {
    logic [3:0]  symbol;
    logic [1:0]  side;
    logic [31:0] end_stamp;
    logic [31:0] start_stamp;
    logic [31:0] open_price;
    logic [31:0] high_price;
    logic [31:0] low_price;
    logic [31:0] close_price;
    logic [31:0] event_count;
    logic        last_of_run;
  } candle_t;

  typedef struct packed {
    logic [31:0] o, h, l, c;
  } bar_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = ohlc_pkg::CFG_INTERVAL;
  logic [31:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_req_type = ohlc_pkg::REQ_BID;
  logic [3:0] in_symbol = '0;
  logic [31:0] in_seconds = '0, in_value_a = '0, in_value_b = '0;
  logic [31:0] in_cdl_open = '0, in_cdl_high = '0, in_cdl_low = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [3:0] out_symbol;
  logic [1:0] out_side;
  logic [31:0] out_end_stamp, out_start_stamp, out_open_price, out_high_price;
  logic [31:0] out_low_price, out_close_price, out_event_count;
  logic out_last_of_run;

  ohlc_candle_aggregator dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // predictor state
  logic [31:0] interval_s = ohlc_pkg::DefaultInterval, offset_s = '0;
  logic        dry = 1'b0;
  logic [31:0] bucket_end = '0;
  bar_t        bars [3][ohlc_pkg::SymbolSlots];
  logic [31:0] counts [3][ohlc_pkg::SymbolSlots];
  candle_t     expected_candles [$];
  int          errors = 0;
  logic        hold_active = 1'b0;
  event        hold_go;
  logic [31:0] clock_s = 32'd1000;

  function automatic logic [31:0] align_down(input logic [31:0] s);
    logic [31:0] rem;
    rem = (interval_s == 0) ? 32'd0 : (s - offset_s) % interval_s;
    return s - rem;
  endfunction

  function automatic void clear_bars();
    for (int k = 0; k < 3; k++)
      for (int i = 0; i < ohlc_pkg::SymbolSlots; i++) begin
        bars[k][i] = '0;
        counts[k][i] = '0;
      end
  endfunction

  function automatic void push_candle(input int slot, input int sd);
    candle_t c;
    c.symbol = 4'(slot);
    c.side = 2'(sd);
    c.end_stamp = bucket_end;
    c.start_stamp = bucket_end - interval_s;
    {c.open_price, c.high_price, c.low_price, c.close_price} = bars[sd][slot];
    c.event_count = counts[sd][slot];
    c.last_of_run = 1'b0;
    expected_candles.push_back(c);
  endfunction

  function automatic void emit_candles();
    int n0;
    candle_t c;
    n0 = expected_candles.size();
    if (dry) return;
    for (int i = 0; i < ohlc_pkg::SymbolSlots; i++) begin
      if (counts[ohlc_pkg::SIDE_BID][i] != 0 || counts[ohlc_pkg::SIDE_ASK][i] != 0) begin
        push_candle(i, ohlc_pkg::SIDE_BID);
        push_candle(i, ohlc_pkg::SIDE_ASK);
      end
      if (counts[ohlc_pkg::SIDE_TRADE][i] != 0) push_candle(i, ohlc_pkg::SIDE_TRADE);
    end
    if (expected_candles.size() > n0) begin
      c = expected_candles.pop_back();
      c.last_of_run = 1'b1;
      expected_candles.push_back(c);
    end
  endfunction

  function automatic void merge_price(input int sd, input int slot, input logic [31:0] v);
    bar_t b;
    b = bars[sd][slot];
    b.c = v;
    if (counts[sd][slot] == 0) begin
      b.o = v; b.h = v; b.l = v;
    end else if (v > b.h) begin
      b.h = v;
    end else if (v < b.l) begin
      b.l = v;
    end
    bars[sd][slot] = b;
    counts[sd][slot] = counts[sd][slot] + 1;
  endfunction

  function automatic void merge_candle(input int sd, input int slot, input logic [31:0] o,
                                       input logic [31:0] h, input logic [31:0] l,
                                       input logic [31:0] c);
    bar_t b;
    b = bars[sd][slot];
    if (counts[sd][slot] == 0) begin
      b.o = o; b.h = h; b.l = l;
    end else begin
      if (h > b.h) b.h = h;
      if (l < b.l) b.l = l;
    end
    b.c = c;
    bars[sd][slot] = b;
    counts[sd][slot] = counts[sd][slot] + 1;
  endfunction

  function automatic void predict_request(input logic [3:0] rt, input logic [3:0] sym,
                                          input logic [31:0] sec, input logic [31:0] va,
                                          input logic [31:0] vb, input logic [31:0] co,
                                          input logic [31:0] ch, input logic [31:0] cl);
    logic span, roll;
    logic [31:0] al;
    if (rt > ohlc_pkg::REQ_FLUSH) return;
    if (rt == ohlc_pkg::REQ_FLUSH) begin
      emit_candles();
      clear_bars();
      bucket_end = '0;
      return;
    end
    span = rt >= ohlc_pkg::REQ_SNAP;
    if (bucket_end == 0) roll = 1'b1;
    else if (span) roll = sec > bucket_end;
    else roll = sec >= bucket_end;
    if (roll) begin
      al = align_down(sec);
      emit_candles();
      bucket_end = (!span || sec != al) ? al + interval_s : sec;
      clear_bars();
    end
    if (sym >= ohlc_pkg::SymbolSlots) return;
    case (rt)
      ohlc_pkg::REQ_BID:   merge_price(ohlc_pkg::SIDE_BID, sym, va);
      ohlc_pkg::REQ_ASK:   merge_price(ohlc_pkg::SIDE_ASK, sym, va);
      ohlc_pkg::REQ_TRADE: merge_price(ohlc_pkg::SIDE_TRADE, sym, va);
      ohlc_pkg::REQ_PAIR, ohlc_pkg::REQ_SNAP: begin
        merge_price(ohlc_pkg::SIDE_BID, sym, va);
        merge_price(ohlc_pkg::SIDE_ASK, sym, vb);
      end
      ohlc_pkg::REQ_CDL_BID: merge_candle(ohlc_pkg::SIDE_BID, sym, co, ch, cl, va);
      ohlc_pkg::REQ_CDL_ASK: merge_candle(ohlc_pkg::SIDE_ASK, sym, co, ch, cl, va);
      default:               merge_candle(ohlc_pkg::SIDE_TRADE, sym, co, ch, cl, va);
    endcase
  endfunction

  // sender burst state
  int burst_left = 0;

  task automatic send_request(input logic [3:0] rt, input logic [3:0] sym,
                              input logic [31:0] sec, input logic [31:0] va,
                              input logic [31:0] vb, input logic [31:0] co,
                              input logic [31:0] ch, input logic [31:0] cl);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 2) != 0) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_req_type <= rt;
    in_symbol <= sym;
    in_seconds <= sec;
    in_value_a <= va;
    in_value_b <= vb;
    in_cdl_open <= co;
    in_cdl_high <= ch;
    in_cdl_low <= cl;
    do @(posedge clk); while (!in_ready);
    predict_request(rt, sym, sec, va, vb, co, ch, cl);
  endtask

  task automatic send_random(input int mode);
    logic [3:0] rt;
    logic [31:0] sec, va, vb, lo, hi;
    rt = 4'($urandom_range(0, 7));
    if ($urandom_range(0, 40) == 0) rt = ohlc_pkg::REQ_FLUSH;
    if ($urandom_range(0, 30) == 0) rt = 4'($urandom_range(9, 15));
    // mode 0 advances time in small steps, other modes jump to random stamps
    if (mode == 0) clock_s = clock_s + $urandom_range(0, 120);
    else clock_s = $urandom();
    sec = clock_s;
    va = ($urandom_range(0, 3) == 0) ? $urandom() : 32'd5000 + $urandom_range(0, 200);
    vb = ($urandom_range(0, 3) == 0) ? $urandom() : va + $urandom_range(0, 20);
    lo = va - $urandom_range(0, 50);
    hi = va + $urandom_range(0, 50);
    send_request(rt, 4'($urandom_range(0, 15)), sec, va, vb, $urandom(), hi, lo);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_candles.size() != 0) @(posedge clk);
    // a request without results may still be running its remainder unit
    repeat (200) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      ohlc_pkg::CFG_INTERVAL: interval_s = val;
      ohlc_pkg::CFG_OFFSET:   offset_s = val;
      default:                dry = val[0];
    endcase
  endtask

  task automatic test_directed();
    send_request(ohlc_pkg::REQ_TRADE, 4'd3, 32'd1000, 32'd100, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_TRADE, 4'd3, 32'd1001, 32'd150, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_TRADE, 4'd3, 32'd1002, 32'd50, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_BID, 4'd0, 32'd1010, 32'hffff_ffff, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_ASK, 4'd15, 32'd1011, 32'd0, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_PAIR, 4'd5, 32'd1020, 32'd10, 32'd12, '0, '0, '0);
    send_request(ohlc_pkg::REQ_CDL_BID, 4'd5, 32'd1030, 32'd9, '0, 32'd8, 32'd20, 32'd1);
    send_request(ohlc_pkg::REQ_CDL_ASK, 4'd7, 32'd1040, 32'd30, '0, 32'd25, 32'd40, 32'd20);
    send_request(ohlc_pkg::REQ_CDL_ASK, 4'd7, 32'd1041, 32'd31, '0, 32'd0, 32'd45, 32'd10);
    send_request(ohlc_pkg::REQ_CDL_TRD, 4'd9, 32'd1050, 32'd7, '0, 32'd6, 32'd8, 32'd5);
    send_request(4'd12, 4'd1, 32'd1051, 32'd7, '0, '0, '0, '0);
    // tick at the bucket end rolls, snapshot at an aligned stamp does not
    send_request(ohlc_pkg::REQ_BID, 4'd1, 32'd1200, 32'd11, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_SNAP, 4'd2, 32'd1500, 32'd4, 32'd6, '0, '0, '0);
    send_request(ohlc_pkg::REQ_SNAP, 4'd2, 32'd1800, 32'd5, 32'd7, '0, '0, '0);
    send_request(ohlc_pkg::REQ_CDL_TRD, 4'd2, 32'd2100, 32'd5, '0, 32'd3, 32'd9, 32'd2);
    send_request(ohlc_pkg::REQ_TRADE, 4'd4, 32'hffff_ffff, 32'd1, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_FLUSH, 4'd0, 32'd0, '0, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_FLUSH, 4'd0, 32'd0, '0, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_ASK, 4'd6, 32'd0, 32'd3, '0, '0, '0, '0);
    send_request(ohlc_pkg::REQ_FLUSH, 4'd0, 32'd0, '0, '0, '0, '0, '0);
  endtask

  task automatic test_random_phase(input int count, input int mode);
    for (int i = 0; i < count; i++) send_random(mode);
    send_request(ohlc_pkg::REQ_FLUSH, 4'($urandom()), $urandom(), '0, '0, '0, '0, '0);
  endtask

  task automatic test_backpressure();
    wait_drained();
    -> hold_go;
    for (int i = 0; i < 30; i++) begin
      clock_s = clock_s + 70;
      send_request(4'($urandom_range(0, 4)), 4'($urandom_range(0, 15)), clock_s,
                   $urandom(), $urandom(), '0, '0, '0);
    end
  endtask

  task automatic test_settings();
    write_reg(ohlc_pkg::CFG_INTERVAL, 32'd1);
    write_reg(ohlc_pkg::CFG_OFFSET, 32'hffff_ffff);
    test_random_phase(30, 0);
    write_reg(ohlc_pkg::CFG_INTERVAL, 32'hffff_ffff);
    write_reg(ohlc_pkg::CFG_OFFSET, 32'd17);
    test_random_phase(30, 1);
    write_reg(ohlc_pkg::CFG_INTERVAL, 32'd0);
    test_random_phase(25, 0);
    write_reg(ohlc_pkg::CFG_INTERVAL, 32'd60);
    write_reg(ohlc_pkg::CFG_OFFSET, 32'd7);
    write_reg(ohlc_pkg::CFG_DRY, 32'd1);
    test_random_phase(20, 0);
    write_reg(ohlc_pkg::CFG_DRY, 32'd0);
    test_random_phase(110, 0);
    write_reg(ohlc_pkg::CFG_INTERVAL, ohlc_pkg::DefaultInterval);
    write_reg(ohlc_pkg::CFG_OFFSET, 32'd0);
    test_random_phase(50, 1);
  endtask

  // long hold-off, counted in its own process
  initial begin
    forever begin
      @(hold_go);
      hold_active <= 1'b1;
      repeat (400) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  // receiver: own stall pattern plus the long hold-off
  always @(posedge clk) begin
    if (hold_active) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 9) < 6) || ((($urandom() >> 4) & 3) == 0);
    end
  end

  always @(posedge clk) begin
    candle_t got, want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_symbol, out_side, out_end_stamp, out_start_stamp, out_open_price,
             out_high_price, out_low_price, out_close_price, out_event_count,
             out_last_of_run};
      if (expected_candles.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected candle %p", got);
      end else begin
        want = expected_candles.pop_front();
        if (got !== want) begin
          errors++;
          if (errors <= 10) $display("candle mismatch: expected %p actual %p", want, got);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    clear_bars();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_settings();
    wait_drained();
    if (errors == 0 && expected_candles.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule

// ===== files.f =====
hdl/ohlc_pkg.sv
hdl/ohlc_datapath.sv
hdl/ohlc_ctrl.sv
hdl/ohlc_candle_aggregator.sv
bench/tb_ohlc_candle_aggregator.sv
